FILE: hw/rtl/essu_pkg.sv
package essu_pkg;

  // Field widths.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned DurW     = 16;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned NumW     = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Fixed constants of the start sequence.
  localparam int unsigned IdleWaitMs = 300;
  localparam int unsigned PctFloor   = 5;
  localparam int unsigned PctSpan    = 95;
  localparam int unsigned PctMax     = 100;

  // Division by 95 as a multiply by ceil(2^22 / 95) and a shift by 22; exact for
  // every numerator below 2^15.
  localparam int unsigned PctNumW  = 15;
  localparam int unsigned PctRecip = 44151;
  localparam int unsigned PctShift = 22;
  localparam int unsigned PctProdW = 31;

  // Register reset values.
  localparam logic [AngleW-1:0] IdleAngleRst    = 8'd20;
  localparam logic [AngleW-1:0] MaxAngleRst     = 8'd160;
  localparam logic [DurW-1:0]   CrankTimeRst    = 16'd2000;
  localparam logic [PctW-1:0]   StageOnePctRst  = 7'd50;
  localparam logic [DurW-1:0]   StageDurRst     = 16'd2000;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdleAngle   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAngle    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCrankTime   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStageOnePct = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStageOneMs  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStageTwoMs  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgStageThrMs  = 3'd6;

  // Sequence phases as seen on the result.
  localparam logic [PhaseW-1:0] PhIdle   = 3'd0;
  localparam logic [PhaseW-1:0] PhWait   = 3'd1;
  localparam logic [PhaseW-1:0] PhCrank  = 3'd2;
  localparam logic [PhaseW-1:0] PhRamp1  = 3'd3;
  localparam logic [PhaseW-1:0] PhRamp2  = 3'd4;
  localparam logic [PhaseW-1:0] PhRamp3  = 3'd5;
  localparam logic [PhaseW-1:0] PhManual = 3'd6;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             start_pressed;
    logic             stop_pressed;
    logic             stop_cooldown;
    logic             manual_mode;
    logic             local_override;
    logic [PctW-1:0]  target_percent;
  } in_t;

  typedef struct packed {
    logic              relay_on;
    logic              servo_write;
    logic [AngleW-1:0] servo_angle;
    logic [PhaseW-1:0] phase;
    logic              in_progress;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pct_mul;
    logic ramp_mul;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_pct;
    logic need_ramp;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/essu_div.sv
module essu_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [essu_pkg::NumW-1:0]     dividend_i,
  input  logic [essu_pkg::DurW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [essu_pkg::NumW-1:0]     quotient_o
);

  localparam int unsigned CntW = $clog2(essu_pkg::NumW + 1);

  logic [essu_pkg::NumW-1:0] shift_q, shift_d;
  logic [essu_pkg::DurW-1:0] rem_q, rem_d;
  logic [essu_pkg::DurW-1:0] dvs_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [essu_pkg::DurW:0]   trial;
  logic [essu_pkg::DurW:0]   diff;
  logic                      fits;

  // One restoring step per cycle: the quotient bits shift in behind the dividend.
  always_comb begin
    trial   = {rem_q, shift_q[essu_pkg::NumW-1]};
    diff    = trial - {1'b0, dvs_q};
    fits    = (trial >= {1'b0, dvs_q});
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      shift_d = {shift_q[essu_pkg::NumW-2:0], fits};
      rem_d   = fits ? diff[essu_pkg::DurW-1:0] : trial[essu_pkg::DurW-1:0];
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(essu_pkg::NumW);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

FILE: hw/rtl/essu_dp.sv
module essu_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [essu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [essu_pkg::CfgDataW-1:0]   cfg_data_i,
  input  essu_pkg::in_t                   in_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output essu_pkg::out_t                  out_o,
  input  essu_pkg::cmd_t                  cmd_i,
  output essu_pkg::sts_t                  sts_o
);

  // Configuration registers.
  logic [essu_pkg::AngleW-1:0] idle_q, max_q;
  logic [essu_pkg::DurW-1:0]   crank_q, s1_ms_q, s2_ms_q, s3_ms_q;
  logic [essu_pkg::PctW-1:0]   s1_pct_q;

  // Sequence state.
  logic [essu_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                        active_q, active_d;
  logic                        relay_q, relay_d;
  logic [essu_pkg::TimeW-1:0]  pstart_q, pstart_d;
  logic [essu_pkg::AngleW-1:0] from_q, from_d, to_q, to_d;

  // Working registers for the item in flight.
  essu_pkg::in_t               in_q;
  logic [essu_pkg::TimeW-1:0]  elapsed_q;
  logic [essu_pkg::NumW-1:0]   num_q;
  logic                        div_go_q;
  logic                        pct_go_q;
  logic                        pct_zero_q;
  logic [essu_pkg::AngleW-1:0] pct_res_q, ramp_res_q;

  logic                        out_valid_q;
  essu_pkg::out_t              out_q;

  logic [essu_pkg::DurW-1:0]   dur;
  logic                        done;
  logic                        force_off;
  logic [essu_pkg::PctW-1:0]   p_raw, p_sat, pm5;
  logic [14:0]                 idle95;
  logic signed [8:0]           span_s;
  logic signed [16:0]          prod_s;
  logic signed [17:0]          pnum_s;
  logic [essu_pkg::PctProdW-1:0] pct_prod;
  logic [essu_pkg::DurW-1:0]   el16, rest16;
  logic [essu_pkg::NumW-1:0]   rnum;
  logic                        div_done;
  logic [essu_pkg::NumW-1:0]   quotient;
  logic [essu_pkg::AngleW-1:0] pct_ang, ang, cur;
  logic                        wr, moved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q   <= essu_pkg::IdleAngleRst;
      max_q    <= essu_pkg::MaxAngleRst;
      crank_q  <= essu_pkg::CrankTimeRst;
      s1_pct_q <= essu_pkg::StageOnePctRst;
      s1_ms_q  <= essu_pkg::StageDurRst;
      s2_ms_q  <= essu_pkg::StageDurRst;
      s3_ms_q  <= essu_pkg::StageDurRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        essu_pkg::CfgIdleAngle:   idle_q   <= cfg_data_i[essu_pkg::AngleW-1:0];
        essu_pkg::CfgMaxAngle:    max_q    <= cfg_data_i[essu_pkg::AngleW-1:0];
        essu_pkg::CfgCrankTime:   crank_q  <= cfg_data_i;
        essu_pkg::CfgStageOnePct: s1_pct_q <= cfg_data_i[essu_pkg::PctW-1:0];
        essu_pkg::CfgStageOneMs:  s1_ms_q  <= cfg_data_i;
        essu_pkg::CfgStageTwoMs:  s2_ms_q  <= cfg_data_i;
        essu_pkg::CfgStageThrMs:  s3_ms_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Duration that closes the current phase.
  always_comb begin
    case (phase_q)
      essu_pkg::PhWait:  dur = essu_pkg::DurW'(essu_pkg::IdleWaitMs);
      essu_pkg::PhCrank: dur = crank_q;
      essu_pkg::PhRamp1: dur = s1_ms_q;
      essu_pkg::PhRamp2: dur = s2_ms_q;
      essu_pkg::PhRamp3: dur = s3_ms_q;
      default:           dur = '0;
    endcase
  end

  assign done      = (elapsed_q >= {{(essu_pkg::TimeW-essu_pkg::DurW){1'b0}}, dur});
  assign force_off = in_q.stop_pressed || in_q.stop_cooldown;

  always_comb begin
    sts_o.need_pct  = !force_off && (
                        (phase_q == essu_pkg::PhCrank && done && !in_q.manual_mode) ||
                        (phase_q == essu_pkg::PhRamp2 && done && !in_q.manual_mode) ||
                        (phase_q == essu_pkg::PhRamp3 && in_q.local_override &&
                         !in_q.manual_mode));
    sts_o.need_ramp = !force_off && !in_q.manual_mode && !done &&
                      (phase_q == essu_pkg::PhRamp1 || phase_q == essu_pkg::PhRamp2 ||
                       phase_q == essu_pkg::PhRamp3);
    sts_o.div_done  = div_done || pct_go_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Percent to angle numerator: 95*idle + (p-5)*(max-idle), never negative for p >= 5.
  assign p_raw  = (phase_q == essu_pkg::PhCrank) ? s1_pct_q : in_q.target_percent;
  assign p_sat  = (p_raw > essu_pkg::PctW'(essu_pkg::PctMax)) ?
                  essu_pkg::PctW'(essu_pkg::PctMax) : p_raw;
  assign pm5    = p_sat - essu_pkg::PctW'(essu_pkg::PctFloor);
  assign idle95 = 15'(idle_q) * 15'(essu_pkg::PctSpan);
  assign span_s = $signed({1'b0, max_q}) - $signed({1'b0, idle_q});
  assign prod_s = $signed({10'd0, pm5}) * span_s;
  assign pnum_s = $signed({3'd0, idle95}) + 18'(prod_s);

  // The numerator is at most 95*255, so the reciprocal multiply gives the exact quotient.
  assign pct_prod = essu_pkg::PctProdW'(num_q[essu_pkg::PctNumW-1:0]) *
                    essu_pkg::PctProdW'(essu_pkg::PctRecip);

  // Ramp numerator written as from*(dur-elapsed) + to*elapsed; elapsed < dur here.
  assign el16   = elapsed_q[essu_pkg::DurW-1:0];
  assign rest16 = dur - el16;
  assign rnum   = ({16'd0, from_q} * {8'd0, rest16}) + ({16'd0, to_q} * {8'd0, el16});

  essu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (num_q),
    .divisor_i  (dur),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
      pct_go_q <= 1'b0;
    end else begin
      div_go_q <= cmd_i.ramp_mul;
      pct_go_q <= cmd_i.pct_mul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q      <= in_i;
      elapsed_q <= in_i.now_ms - pstart_q;
    end
    if (cmd_i.pct_mul) begin
      num_q      <= essu_pkg::NumW'(pnum_s[16:0]);
      pct_zero_q <= (p_sat < essu_pkg::PctW'(essu_pkg::PctFloor));
    end else if (cmd_i.ramp_mul) begin
      num_q <= rnum;
    end
    if (pct_go_q) begin
      pct_res_q <= pct_prod[essu_pkg::PctShift +: essu_pkg::AngleW];
    end
    if (div_done) begin
      ramp_res_q <= quotient[essu_pkg::AngleW-1:0];
    end
  end

  assign pct_ang = pct_zero_q ? '0 : pct_res_q;

  // Next sequence state and the result of this update.
  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    relay_d  = relay_q;
    pstart_d = pstart_q;
    from_d   = from_q;
    to_d     = to_q;
    wr       = 1'b0;
    ang      = '0;
    moved    = 1'b0;
    cur      = done ? to_q : ramp_res_q;
    if (force_off) begin
      active_d = 1'b0;
      phase_d  = essu_pkg::PhIdle;
      relay_d  = 1'b0;
      wr       = 1'b1;
    end else begin
      case (phase_q)
        essu_pkg::PhIdle: begin
          if (in_q.manual_mode && active_q) begin
            active_d = 1'b0;
          end else if (in_q.start_pressed && !active_q) begin
            wr       = 1'b1;
            ang      = idle_q;
            pstart_d = in_q.now_ms;
            active_d = 1'b1;
            if (in_q.manual_mode) begin
              relay_d = 1'b1;
              phase_d = essu_pkg::PhCrank;
            end else begin
              phase_d = essu_pkg::PhWait;
            end
          end
        end
        essu_pkg::PhWait: begin
          if (!in_q.manual_mode && done) begin
            relay_d  = 1'b1;
            pstart_d = in_q.now_ms;
            phase_d  = essu_pkg::PhCrank;
          end
        end
        essu_pkg::PhCrank: begin
          if (done) begin
            relay_d  = 1'b0;
            pstart_d = in_q.now_ms;
            if (in_q.manual_mode) begin
              phase_d  = essu_pkg::PhManual;
              active_d = 1'b0;
            end else begin
              from_d  = idle_q;
              to_d    = pct_ang;
              phase_d = essu_pkg::PhRamp1;
            end
          end
        end
        essu_pkg::PhRamp1: begin
          if (!in_q.manual_mode) begin
            wr = 1'b1;
            if (done) begin
              ang      = to_q;
              from_d   = to_q;
              to_d     = max_q;
              pstart_d = in_q.now_ms;
              phase_d  = essu_pkg::PhRamp2;
            end else begin
              ang = ramp_res_q;
            end
          end
        end
        essu_pkg::PhRamp2: begin
          if (!in_q.manual_mode) begin
            wr = 1'b1;
            if (done) begin
              ang      = max_q;
              from_d   = max_q;
              to_d     = pct_ang;
              pstart_d = in_q.now_ms;
              phase_d  = essu_pkg::PhRamp3;
            end else begin
              ang = ramp_res_q;
            end
          end
        end
        essu_pkg::PhRamp3: begin
          if (!in_q.manual_mode) begin
            wr    = 1'b1;
            moved = in_q.local_override && (pct_ang != to_q);
            if (moved) begin
              from_d   = cur;
              to_d     = pct_ang;
              pstart_d = in_q.now_ms;
              ang      = cur;
            end else if (done) begin
              ang      = to_q;
              phase_d  = essu_pkg::PhManual;
              active_d = 1'b0;
            end else begin
              ang = ramp_res_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= essu_pkg::PhIdle;
      active_q <= 1'b0;
      relay_q  <= 1'b0;
      pstart_q <= '0;
      from_q   <= '0;
      to_q     <= '0;
    end else if (cmd_i.commit) begin
      phase_q  <= phase_d;
      active_q <= active_d;
      relay_q  <= relay_d;
      pstart_q <= pstart_d;
      from_q   <= from_d;
      to_q     <= to_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.relay_on    <= relay_d;
      out_q.servo_write <= wr;
      out_q.servo_angle <= wr ? ang : '0;
      out_q.phase       <= phase_d;
      out_q.in_progress <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hw/rtl/essu_ctrl.sv
module essu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  essu_pkg::sts_t sts_i,
  output essu_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_PMUL   = 3'd2;
  localparam logic [2:0] S_PDIV   = 3'd3;
  localparam logic [2:0] S_RMUL   = 3'd4;
  localparam logic [2:0] S_RDIV   = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.pct_mul  = 1'b0;
    cmd_o.ramp_mul = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.need_pct) begin
          state_d = S_PMUL;
        end else if (sts_i.need_ramp) begin
          state_d = S_RMUL;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_PMUL: begin
        cmd_o.pct_mul = 1'b1;
        state_d       = S_PDIV;
      end
      S_PDIV: begin
        if (sts_i.div_done) begin
          state_d = sts_i.need_ramp ? S_RMUL : S_COMMIT;
        end
      end
      S_RMUL: begin
        cmd_o.ramp_mul = 1'b1;
        state_d        = S_RDIV;
      end
      S_RDIV: begin
        if (sts_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_div_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_PDIV || state_q == S_RDIV))
    else $error("divider finished outside a divide wait");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result committed while the output register is occupied");

  a_ramp_still_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDIV) |-> sts_i.need_ramp)
    else $error("ramp divide running for an update that needs no ramp");

  a_no_back_to_back_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o)
    else $error("second transfer taken while an update is in flight");

endmodule

FILE: hw/rtl/engine_start_throttle_sequencer_unit.sv
// Engine start sequencer with a three-stage throttle ramp.
// Each input transfer is one update of the control loop: a millisecond timestamp,
// the start and stop buttons, the mode flags and a requested throttle percent.
// Each update yields exactly one result transfer: starter relay level, a servo
// write strobe with its angle, the sequence phase and the in-progress flag.
// Both channels use valid and stall; a transfer completes on a clock edge with
// valid high and stall low. Configuration registers are written through the
// plain write port while the block is idle; the user must keep to this, as
// the block itself does not enforce it. One update is in flight at a time.
// An update with no arithmetic is loaded, evaluated and committed to the
// output register. A percent-to-angle conversion adds a numerator step, then
// a reciprocal multiply for the division by 95; a ramp interpolation adds a
// multiply step, a divider start, the 24 steps of the restoring divider and
// a step to see it finish. The worst case is a retarget in the final ramp;
// no input is taken before a commit, so the ramp divider sets the throughput.
// A finished result waits in the output register while the receiver stalls;
// the next input transfer is still taken, and its result is held back until
// that register has been emptied.
// Reset returns the sequence to idle with the relay off and the registers at
// their default values; no result is pending afterwards.
module engine_start_throttle_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [essu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [essu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  essu_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output essu_pkg::out_t                out_o
);

  essu_pkg::cmd_t cmd;
  essu_pkg::sts_t sts;

  // The controller sequences each update: evaluate, optional arithmetic, commit.
  essu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the sequence state and the result register.
  essu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: bench/tb_engine_start_throttle_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_engine_start_throttle_sequencer_unit;
  import essu_pkg::*;

  // Flag masks for the directed updates, ordered as
  // {start, stop, cooldown, manual, override}.
  localparam logic [4:0] FStart  = 5'b10000;
  localparam logic [4:0] FStop   = 5'b01000;
  localparam logic [4:0] FCool   = 5'b00100;
  localparam logic [4:0] FManual = 5'b00010;
  localparam logic [4:0] FOvr    = 5'b00001;

  localparam int unsigned SettingCount    = 8;
  localparam int unsigned UpdatesPerSetting = 106;
  // The worst update is a retarget in the final ramp.
  localparam int unsigned DrainCycles     = 64;
  localparam int unsigned TimeoutNs       = 2_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_o;

  engine_start_throttle_sequencer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // The tracker mirrors the sequencer: its registers, its phase and its ramp
  // end points. Every accepted update is run through it at once, and the
  // result it yields waits in a queue until the block delivers its own.
  class throttle_tracker;
    logic [AngleW-1:0] idle_ang, max_ang;
    logic [DurW-1:0]   crank_ms, s1_ms, s2_ms, s3_ms;
    logic [PctW-1:0]   s1_pct;
    logic [PhaseW-1:0] phase;
    logic              active, relay;
    logic [TimeW-1:0]  phase_start;
    logic [AngleW-1:0] from_ang, to_ang;
    out_t              pending[$];
    int unsigned       errors;

    function new();
      idle_ang    = IdleAngleRst;
      max_ang     = MaxAngleRst;
      crank_ms    = CrankTimeRst;
      s1_pct      = StageOnePctRst;
      s1_ms       = StageDurRst;
      s2_ms       = StageDurRst;
      s3_ms       = StageDurRst;
      phase       = PhIdle;
      active      = 1'b0;
      relay       = 1'b0;
      phase_start = '0;
      from_ang    = '0;
      to_ang      = '0;
      errors      = 0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgIdleAngle:   idle_ang = data[AngleW-1:0];
        CfgMaxAngle:    max_ang  = data[AngleW-1:0];
        CfgCrankTime:   crank_ms = data[DurW-1:0];
        CfgStageOnePct: s1_pct   = data[PctW-1:0];
        CfgStageOneMs:  s1_ms    = data[DurW-1:0];
        CfgStageTwoMs:  s2_ms    = data[DurW-1:0];
        CfgStageThrMs:  s3_ms    = data[DurW-1:0];
        default: ;
      endcase
    endfunction

    // Percent to servo angle, linear between idle at the floor percent and
    // full at one hundred; anything above one hundred counts as one hundred.
    function logic [AngleW-1:0] angle_of_pct(logic [PctW-1:0] p);
      longint q, lo, hi, span, floor_pct;
      span      = longint'(PctSpan);
      floor_pct = longint'(PctFloor);
      q         = (p > PctMax) ? longint'(PctMax) : longint'(p);
      lo        = longint'(idle_ang);
      hi        = longint'(max_ang);
      if (q < floor_pct) return '0;
      if (q == floor_pct) return idle_ang;
      return AngleW'((lo * span + (q - floor_pct) * (hi - lo)) / span);
    endfunction

    // Point on the current ramp; only called while el is below dur.
    function logic [AngleW-1:0] ramp_point(logic [TimeW-1:0] el, logic [DurW-1:0] dur);
      longint f, t, e, d;
      f = longint'(from_ang);
      t = longint'(to_ang);
      e = longint'(el);
      d = longint'(dur);
      return AngleW'((f * d + e * (t - f)) / d);
    endfunction

    function void note_update(in_t u);
      logic [TimeW-1:0]  el;
      logic              wr, done, moved;
      logic [AngleW-1:0] ang, req, cur;
      out_t              r;
      el  = u.now_ms - phase_start;
      wr  = 1'b0;
      ang = '0;
      if (u.stop_pressed || u.stop_cooldown) begin
        active = 1'b0;
        phase  = PhIdle;
        relay  = 1'b0;
        wr     = 1'b1;
      end else begin
        case (phase)
          PhIdle: begin
            if (u.manual_mode && active) begin
              active = 1'b0;
            end else if (u.start_pressed && !active) begin
              wr          = 1'b1;
              ang         = idle_ang;
              phase_start = u.now_ms;
              active      = 1'b1;
              if (u.manual_mode) begin
                relay = 1'b1;
                phase = PhCrank;
              end else begin
                phase = PhWait;
              end
            end
          end
          PhWait: begin
            if (!u.manual_mode && el >= IdleWaitMs) begin
              relay       = 1'b1;
              phase_start = u.now_ms;
              phase       = PhCrank;
            end
          end
          PhCrank: begin
            if (el >= crank_ms) begin
              relay       = 1'b0;
              phase_start = u.now_ms;
              if (u.manual_mode) begin
                phase  = PhManual;
                active = 1'b0;
              end else begin
                from_ang = idle_ang;
                to_ang   = angle_of_pct(s1_pct);
                phase    = PhRamp1;
              end
            end
          end
          PhRamp1: begin
            if (!u.manual_mode) begin
              wr = 1'b1;
              if (el >= s1_ms) begin
                ang         = to_ang;
                from_ang    = to_ang;
                to_ang      = max_ang;
                phase_start = u.now_ms;
                phase       = PhRamp2;
              end else begin
                ang = ramp_point(el, s1_ms);
              end
            end
          end
          PhRamp2: begin
            if (!u.manual_mode) begin
              wr = 1'b1;
              if (el >= s2_ms) begin
                ang         = max_ang;
                from_ang    = max_ang;
                to_ang      = angle_of_pct(u.target_percent);
                phase_start = u.now_ms;
                phase       = PhRamp3;
              end else begin
                ang = ramp_point(el, s2_ms);
              end
            end
          end
          PhRamp3: begin
            if (!u.manual_mode) begin
              done  = (el >= s3_ms);
              moved = 1'b0;
              // Under local override a new target restarts the ramp from
              // wherever the throttle stands now.
              if (u.local_override) begin
                req = angle_of_pct(u.target_percent);
                if (req != to_ang) begin
                  cur         = done ? to_ang : ramp_point(el, s3_ms);
                  from_ang    = cur;
                  to_ang      = req;
                  phase_start = u.now_ms;
                  moved       = 1'b1;
                end
              end
              wr = 1'b1;
              if (moved) begin
                ang = from_ang;
              end else if (done) begin
                ang    = to_ang;
                phase  = PhManual;
                active = 1'b0;
              end else begin
                ang = ramp_point(el, s3_ms);
              end
            end
          end
          default: ;
        endcase
      end
      r             = '0;
      r.relay_on    = relay;
      r.servo_write = wr;
      r.servo_angle = wr ? ang : '0;
      r.phase       = phase;
      r.in_progress = active;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no update waiting: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("relay_on", 32'(want.relay_on), 32'(got.relay_on));
      compare_field("servo_write", 32'(want.servo_write), 32'(got.servo_write));
      compare_field("servo_angle", 32'(want.servo_angle), 32'(got.servo_angle));
      compare_field("phase", 32'(want.phase), 32'(got.phase));
      compare_field("in_progress", 32'(want.in_progress), 32'(got.in_progress));
    endfunction
  endclass

  throttle_tracker sb;

  // Stimulus state: the running timestamp and the character of the start
  // sequence currently being played.
  logic [TimeW-1:0] clock_ms;
  logic             seq_manual;
  logic [PctW-1:0]  seq_target;
  logic             tx_gappy;
  int unsigned      burst_left;

  // Receiver stall pattern: it switches between no stalls, short stalls and
  // long stalls on a timer of its own.
  int unsigned rx_mode, rx_timer, stall_left;

  always #2 clk_i = ~clk_i;

  // Result side. The transfer is checked on the edge where it completes, and
  // the stall for the next cycle is chosen afterwards.
  always @(posedge clk_i) begin
    logic hold;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_result(out_o);
    end
    if (rx_timer == 0) begin
      rx_mode  = $urandom_range(0, 2);
      rx_timer = $urandom_range(100, 400);
    end else begin
      rx_timer--;
    end
    hold = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      hold       = 1'b1;
    end else if (rx_mode == 2 && $urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(0, 20);
      hold       = 1'b1;
    end
    out_stall_i <= hold;
  end

  function automatic in_t update_of(logic [TimeW-1:0] t, logic [4:0] flags,
                                    logic [PctW-1:0] pct);
    in_t u;
    u = '0;
    u.now_ms = t;
    {u.start_pressed, u.stop_pressed, u.stop_cooldown, u.manual_mode,
     u.local_override} = flags;
    u.target_percent = pct;
    return u;
  endfunction

  // Builds the next random update. Time advances in steps scaled to the
  // length of the phase the sequencer is in, so that every ramp is sampled a
  // few times on its way; now and then it lands on or just before a phase boundary,
  // jumps anywhere in the 32-bit range, or stands still. Stops, cooldowns
  // and stray mode changes break sequences off at random.
  function automatic in_t compose_update();
    in_t              u;
    logic [TimeW-1:0] span;
    int unsigned      r;
    case (sb.phase)
      PhWait:  span = TimeW'(IdleWaitMs);
      PhCrank: span = TimeW'(sb.crank_ms);
      PhRamp1: span = TimeW'(sb.s1_ms);
      PhRamp2: span = TimeW'(sb.s2_ms);
      PhRamp3: span = TimeW'(sb.s3_ms);
      default: span = 40;
    endcase
    r = $urandom_range(0, 99);
    if (r < 8) begin
      clock_ms = sb.phase_start + span - $urandom_range(0, 1);
    end else if (r < 11) begin
      clock_ms = $urandom();
    end else if (r >= 14) begin
      clock_ms = clock_ms + $urandom_range(1, span / 2 + 1);
    end
    u = '0;
    u.now_ms = clock_ms;
    if (sb.phase == PhIdle && $urandom_range(0, 9) < 7) begin
      u.start_pressed = 1'b1;
      seq_manual      = ($urandom_range(0, 9) < 3);
      seq_target      = PctW'($urandom_range(0, 127));
    end else begin
      u.start_pressed = ($urandom_range(0, 9) == 0);
    end
    u.stop_pressed   = (sb.phase == PhManual) ? ($urandom_range(0, 2) == 0)
                                              : ($urandom_range(0, 59) == 0);
    u.stop_cooldown  = ($urandom_range(0, 79) == 0);
    u.manual_mode    = seq_manual ^ ($urandom_range(0, 19) == 0);
    u.local_override = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) seq_target = PctW'($urandom_range(0, 127));
    u.target_percent = seq_target;
    return u;
  endfunction

  // Offers one update and waits for its transfer. With more set, valid
  // stays high for the next update unless the burst has run out; otherwise
  // valid is dropped.
  task automatic send_update(in_t u, logic more);
    in_i       <= u;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_update(u);
    if (!more) begin
      in_valid_i <= 1'b0;
    end else if (tx_gappy && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_until_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Writes all seven registers on consecutive edges. With pad set the
  // unused upper bits of the narrow registers carry random junk, which the
  // block must ignore.
  task automatic load_settings(logic [AngleW-1:0] idle, logic [AngleW-1:0] full,
                               logic [DurW-1:0] crank, logic [PctW-1:0] pct,
                               logic [DurW-1:0] d1, logic [DurW-1:0] d2,
                               logic [DurW-1:0] d3, logic pad);
    logic [CfgDataW-1:0] data [CfgStageThrMs+1];
    logic [CfgIdxW-1:0]  idx;
    data[CfgIdleAngle]   = {pad ? 8'($urandom) : 8'h00, idle};
    data[CfgMaxAngle]    = {pad ? 8'($urandom) : 8'h00, full};
    data[CfgCrankTime]   = crank;
    data[CfgStageOnePct] = {pad ? 9'($urandom) : 9'h000, pct};
    data[CfgStageOneMs]  = d1;
    data[CfgStageTwoMs]  = d2;
    data[CfgStageThrMs]  = d3;
    for (int i = CfgIdleAngle; i <= CfgStageThrMs; i++) begin
      idx = CfgIdxW'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data[i];
      @(posedge clk_i);
      sb.configure(idx, data[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DurW-1:0] random_span();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 7) return DurW'($urandom_range(1, 400));
    return DurW'($urandom_range(1, 65535));
  endfunction

  initial begin
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    out_stall_i = 1'b0;
    clock_ms    = '0;
    seq_manual  = 1'b0;
    seq_target  = '0;
    tx_gappy    = 1'b1;
    burst_left  = 3;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset settings: a full automatic start with the
    // exact phase boundaries, a start pressed while running, manual mode
    // holding the wait and a ramp, a saturated target, retargets to below
    // the floor percent and to the floor itself, and a manual start whose
    // crank time spans the wrap of the timestamp.
    send_update(update_of(32'd0, FStop | FCool | FManual | FOvr, 7'd127), 1'b1);
    send_update(update_of(32'd5, FCool, 7'd0), 1'b1);
    send_update(update_of(32'd1000, FStart, 7'd100), 1'b1);
    send_update(update_of(32'd1100, FStart, 7'd100), 1'b1);
    send_update(update_of(32'd1299, '0, 7'd100), 1'b1);
    send_update(update_of(32'd1300, FManual, 7'd100), 1'b1);
    send_update(update_of(32'd1300, '0, 7'd100), 1'b1);
    send_update(update_of(32'd3299, '0, 7'd100), 1'b1);
    send_update(update_of(32'd3300, '0, 7'd100), 1'b1);
    send_update(update_of(32'd3300, '0, 7'd100), 1'b1);
    send_update(update_of(32'd4300, FManual, 7'd100), 1'b1);
    send_update(update_of(32'd4301, '0, 7'd100), 1'b1);
    send_update(update_of(32'd5300, '0, 7'd100), 1'b1);
    send_update(update_of(32'd6300, '0, 7'd4), 1'b1);
    send_update(update_of(32'd7300, '0, 7'd127), 1'b1);
    send_update(update_of(32'd7500, FOvr, 7'd4), 1'b1);
    send_update(update_of(32'd8500, FOvr, 7'd5), 1'b1);
    send_update(update_of(32'd9000, FManual, 7'd5), 1'b1);
    send_update(update_of(32'd11000, '0, 7'd5), 1'b1);
    send_update(update_of(32'd11001, FStart, 7'd50), 1'b1);
    send_update(update_of(32'd11002, FStop, 7'd50), 1'b1);
    send_update(update_of(32'hFFFF_FF00, FStart | FManual, 7'd50), 1'b1);
    send_update(update_of(32'h0000_0600, FManual, 7'd50), 1'b1);
    send_update(update_of(32'h0000_06D0, FManual, 7'd50), 1'b1);
    send_update(update_of(32'h0000_06D1, FCool, 7'd0), 1'b0);

    // Random part, one batch per register setting. The first three settings
    // are the extremes: everything at its minimum, everything at its
    // maximum with a falling throttle range, and zero durations with a stage
    // one percent above one hundred and idle equal to full.
    for (int s = 0; s < SettingCount; s++) begin
      wait_until_drained();
      case (s)
        0: load_settings(8'd0, 8'd180, 16'd1, 7'd0, 16'd1, 16'd1, 16'd1, 1'b0);
        1: load_settings(8'd180, 8'd0, 16'd65535, 7'd100, 16'd65535, 16'd65535,
                         16'd65535, 1'b0);
        2: load_settings(8'd90, 8'd90, 16'd0, 7'd127, 16'd0, 16'd0, 16'd0, 1'b1);
        default: load_settings(AngleW'($urandom_range(0, 180)),
                               AngleW'($urandom_range(0, 180)), random_span(),
                               PctW'($urandom_range(0, 127)), random_span(),
                               random_span(), random_span(), 1'b1);
      endcase
      tx_gappy   = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 10);
      for (int n = 0; n < UpdatesPerSetting; n++) begin
        send_update(compose_update(), n != UpdatesPerSetting - 1);
      end
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A result that never arrives or a handshake that hangs ends up here.
  initial begin
    #(TimeoutNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
